// File: hdl/dls_pkg.sv
package dls_pkg;

  localparam int MAX_NEURONS = 128;
  localparam int MAX_INPUTS  = 1024;
  localparam int SIG_ENTRIES = 1024;

  localparam int NEURON_W = $clog2(MAX_NEURONS);
  localparam int COL_W    = $clog2(MAX_INPUTS);
  localparam int SIG_W    = $clog2(SIG_ENTRIES);
  localparam int WADDR_W  = NEURON_W + COL_W;
  localparam int VAL_W    = 16;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int FRAC_W   = 12;
  localparam int SUM_W    = ACC_W + 1;
  localparam int ZF_W     = SUM_W - FRAC_W;
  localparam int COUNT_W  = 8;

  typedef enum logic [2:0] {
    CMD_WEIGHT = 3'd0,
    CMD_BIAS   = 3'd1,
    CMD_FEED   = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FEED,
    B_DRAIN,
    B_RD_MEM,
    B_RD_Z,
    B_RD_OUT
  } back_state_t;

  typedef struct packed {
    cmd_t                    op;
    logic [NEURON_W-1:0]     neuron;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef logic [VAL_W-1:0] sig_table_t [SIG_ENTRIES];

  // Shift-subtract division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-t) in Q.30: Taylor series of exp(-t/16), then squared four times
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] t_in);
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] t;
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    t    = t_in >> 4;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * t) >> 30, 64'(k));
      if (k % 2 == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    term = unsigned'(sum);
    for (int i = 0; i < 4; i++) term = (term * term) >> 30;
    return term;
  endfunction

  // Sigmoid at each bin midpoint, Q4.12 rounded to nearest
  function automatic sig_table_t build_sig_table();
    sig_table_t tbl;
    logic signed [63:0] mid;
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      mid = -(64'sd1 <<< 27) + ((64'sd2 * i + 64'sd1) <<< (27 - SIG_W));
      mag = unsigned'(mid < 0 ? -mid : mid);
      e   = exp_neg_q30(mag << 6);
      den = (64'd1 << 30) + e;
      num = (mid >= 0) ? (64'd4096 << 30) : (64'd4096 * e);
      q   = udiv64(num + (den >> 1), den);
      tbl[i] = q[VAL_W-1:0];
    end
    return tbl;
  endfunction

endpackage

// File: hdl/dls_front.sv
module dls_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      command,
  input  logic [dls_pkg::NEURON_W-1:0]    neuron,
  input  logic [dls_pkg::COL_W-1:0]       column,
  input  logic signed [dls_pkg::VAL_W-1:0] value,
  output dls_pkg::item_t                  head,
  output logic                            head_valid,
  input  logic                            head_pop
);
  import dls_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       known;
  logic       push;
  logic       pop;

  // classify: unknown codes are dropped here
  assign known = command inside {CMD_WEIGHT, CMD_BIAS, CMD_FEED, CMD_READ, CMD_CLEAR};
  assign busy  = (count == 2'd2);
  assign push  = start && !busy && known;
  assign pop   = head_pop && head_valid;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != 2'd0);

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: cmd_t'(command), neuron: neuron, column: column, value: value};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hdl/dls_sigmoid.sv
module dls_sigmoid (
  input  logic                            clk,
  input  logic signed [dls_pkg::VAL_W-1:0] z,
  output logic [dls_pkg::VAL_W-1:0]       entry
);
  import dls_pkg::*;

  localparam sig_table_t SIG_ROM = build_sig_table();

  logic [VAL_W-1:0] zoff;
  logic [SIG_W-1:0] idx;

  // offset z to unsigned and keep the top bits as the bin
  assign zoff = z ^ {1'b1, {(VAL_W-1){1'b0}}};
  assign idx  = zoff[VAL_W-1 -: SIG_W];

  always_ff @(posedge clk) begin
    entry <= SIG_ROM[idx];
  end

endmodule

// File: hdl/dls_back.sv
module dls_back (
  input  logic                             clk,
  input  logic                             rst,
  input  dls_pkg::item_t                   head,
  input  logic                             head_valid,
  output logic                             head_pop,
  input  logic [dls_pkg::COUNT_W-1:0]      active_count,
  input  logic                             linear,
  output logic                             done,
  output logic [dls_pkg::NEURON_W-1:0]     neuron_index,
  output logic signed [dls_pkg::VAL_W-1:0] activation
);
  import dls_pkg::*;

  // storage
  logic signed [VAL_W-1:0] weight_mem [MAX_NEURONS * MAX_INPUTS];
  logic signed [VAL_W-1:0] bias_mem   [MAX_NEURONS];
  logic [ACC_W-1:0]        acc_mem    [MAX_NEURONS];
  logic [MAX_NEURONS-1:0]  acc_valid;

  back_state_t state, state_next;

  logic [NEURON_W-1:0]     n;
  logic [NEURON_W-1:0]     rd_neuron;
  logic [COL_W-1:0]        col;
  logic signed [VAL_W-1:0] act;

  logic [NEURON_W-1:0]     acc_raddr;
  logic [WADDR_W-1:0]      w_raddr;
  logic                    issue;
  logic                    w_we;
  logic                    b_we;
  logic                    clear;
  logic                    take;

  logic [ACC_W-1:0]        acc_q;
  logic                    acc_vq;
  logic signed [VAL_W-1:0] bias_q;
  logic signed [VAL_W-1:0] w_q;

  logic                    s1_valid;
  logic [NEURON_W-1:0]     s1_n;
  logic                    s2_valid;
  logic [NEURON_W-1:0]     s2_n;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]        acc_d;

  logic [ACC_W-1:0]        acc_eff;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [ZF_W-1:0]  zf;
  logic signed [VAL_W-1:0] z_sat;
  logic signed [VAL_W-1:0] z;
  logic [VAL_W-1:0]        sig;

  localparam logic signed [ZF_W-1:0] Z_MAX = ZF_W'(32767);
  localparam logic signed [ZF_W-1:0] Z_MIN = -ZF_W'(32768);

  assign w_raddr = {n, col};
  assign w_we  = take && (head.op == CMD_WEIGHT);
  assign b_we  = take && (head.op == CMD_BIAS);
  assign clear = take && (head.op == CMD_CLEAR);

  // next state and control
  always_comb begin
    state_next = state;
    head_pop   = 1'b0;
    take       = 1'b0;
    issue      = 1'b0;
    acc_raddr  = n;
    case (state)
      B_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          take     = 1'b1;
          case (head.op)
            CMD_FEED: begin
              if (active_count != '0) state_next = B_FEED;
            end
            CMD_READ: begin
              acc_raddr = head.neuron;
              if ({1'b0, head.neuron} < active_count) state_next = B_RD_MEM;
            end
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_FEED: begin
        issue = 1'b1;
        if ({1'b0, n} == active_count - 1'b1) state_next = B_DRAIN;
      end
      B_DRAIN: begin
        if (!s1_valid && !s2_valid) state_next = B_IDLE;
      end
      B_RD_MEM: state_next = B_RD_Z;
      B_RD_Z:   state_next = B_RD_OUT;
      B_RD_OUT: state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      n         <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      acc_valid <= '0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (state == B_IDLE) n <= '0;
      else if (issue) n <= n + 1'b1;
      if (clear) acc_valid <= '0;
      else if (s2_valid) acc_valid[s2_n] <= 1'b1;
    end
  end

  // memories: registered reads, single write ports
  always_ff @(posedge clk) begin
    acc_q  <= acc_mem[acc_raddr];
    acc_vq <= acc_valid[acc_raddr];
    bias_q <= bias_mem[acc_raddr];
    w_q    <= weight_mem[w_raddr];
    if (w_we) weight_mem[{head.neuron, head.column}] <= head.value;
    if (b_we) bias_mem[head.neuron] <= head.value;
    if (s2_valid) acc_mem[s2_n] <= acc_d + ACC_W'(prod);
  end

  // latch the item and run the multiply-accumulate pipe
  always_ff @(posedge clk) begin
    if (take) begin
      rd_neuron <= head.neuron;
      col       <= head.column;
      act       <= head.value;
    end
    s1_n  <= n;
    s2_n  <= s1_n;
    prod  <= w_q * act;
    acc_d <= acc_vq ? acc_q : '0;
  end

  // add bias, round half up, saturate
  always_comb begin
    acc_eff = acc_vq ? acc_q : '0;
    sum   = signed'({acc_eff[ACC_W-1], acc_eff})
          + (SUM_W'(bias_q) <<< FRAC_W);
    sum_r = sum + SUM_W'(2048);
    zf    = sum_r[SUM_W-1:FRAC_W];
    if (zf > Z_MAX) z_sat = 16'sh7fff;
    else if (zf < Z_MIN) z_sat = -16'sh8000;
    else z_sat = zf[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == B_RD_MEM) z <= z_sat;
  end

  dls_sigmoid u_sigmoid (
    .clk   (clk),
    .z     (z),
    .entry (sig)
  );

  // present the result for one cycle
  assign done         = (state == B_RD_OUT);
  assign neuron_index = rd_neuron;
  assign activation   = linear ? z : signed'(sig);

endmodule

// File: hdl/dense_layer_sigmoid_forward.sv
// Fully connected layer with sigmoid output, Q4.12 fixed point.
// Command channel: raise start with command, neuron, column and value; the
// item is taken at a clock edge where start is high and busy is low. Items
// go into a two-entry queue, so busy only rises when that queue is full.
// Commands: write weight, write bias, feed activation, read neuron, clear.
// Codes 5 to 7 are dropped.
// A feed runs one multiply-accumulate per cycle through the single port of
// the weight memory, one per active neuron, then drains. Writes and clear
// act at the queue head; reads pass accumulator, z and sigmoid registers.
// Result channel: done is high for exactly one cycle with neuron_index and
// activation; the receiver cannot stall it. Reads of neurons not in use give
// nothing.
// Config port: cfg_write, cfg_index (0 neuron_count, 1 linear_output) and
// cfg_data; write only while idle.
// Reset: accumulators read as zero, neuron_count 128, sigmoid mode. Weight
// and bias memories hold garbage until written.
module dense_layer_sigmoid_forward (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       command,
  input  logic [dls_pkg::NEURON_W-1:0]     neuron,
  input  logic [dls_pkg::COL_W-1:0]        column,
  input  logic signed [dls_pkg::VAL_W-1:0] value,
  output logic                             done,
  output logic [dls_pkg::NEURON_W-1:0]     neuron_index,
  output logic signed [dls_pkg::VAL_W-1:0] activation,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [dls_pkg::COUNT_W-1:0]      cfg_data
);
  import dls_pkg::*;

  localparam logic CFG_COUNT  = 1'b0;
  localparam logic CFG_LINEAR = 1'b1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_NEURONS);

  logic [COUNT_W-1:0] neuron_count;
  logic               linear_output;
  logic [COUNT_W-1:0] active_count;
  item_t              head;
  logic               head_valid;
  logic               head_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      neuron_count  <= COUNT_MAX;
      linear_output <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COUNT:  neuron_count  <= cfg_data;
        CFG_LINEAR: linear_output <= cfg_data[0];
        default:    neuron_count  <= neuron_count;
      endcase
    end
  end

  // clamp to the neurons that exist
  assign active_count = (neuron_count > COUNT_MAX) ? COUNT_MAX : neuron_count;

  dls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .neuron     (neuron),
    .column     (column),
    .value      (value),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  dls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop),
    .active_count (active_count),
    .linear       (linear_output),
    .done         (done),
    .neuron_index (neuron_index),
    .activation   (activation)
  );

endmodule

// File: verif/dense_layer_sigmoid_forward_tb.sv
`timescale 1ns / 1ps

module dense_layer_sigmoid_forward_tb;
  import dls_pkg::*;

  localparam int SETTLE_CYCLES = 600;
  localparam int NUM_READY = 2;

  typedef struct {
    logic [NEURON_W-1:0]     neuron_index;
    logic signed [VAL_W-1:0] activation;
  } act_t;

  typedef struct {
    logic [2:0]              cmd;
    logic [NEURON_W-1:0]     neuron;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    bit                      typed;
    logic signed [VAL_W-1:0] typed_act;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] command = '0;
  logic [NEURON_W-1:0] neuron = '0;
  logic [COL_W-1:0] column = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic done;
  logic [NEURON_W-1:0] neuron_index;
  logic signed [VAL_W-1:0] activation;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;

  // Predictor state
  logic signed [VAL_W-1:0] weight_mem [MAX_NEURONS*MAX_INPUTS];
  bit                      weight_set [MAX_NEURONS*MAX_INPUTS];
  int                      col_fill [MAX_INPUTS];
  logic signed [VAL_W-1:0] bias_mem [MAX_NEURONS];
  logic [ACC_W-1:0]        acc_mem [MAX_NEURONS];
  logic [VAL_W-1:0]        sig_lut [SIG_ENTRIES];
  int                      used_neurons;
  bit                      linear_mode;

  act_t pending_acts[$];
  int   mismatches = 0;
  int   reads_checked = 0;
  int   items_sent = 0;
  int   ready_cols [NUM_READY] = '{0, 1023};
  bit   typed_next = 1'b0;
  logic signed [VAL_W-1:0] typed_val;

  dense_layer_sigmoid_forward dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .neuron(neuron), .column(column), .value(value),
    .done(done), .neuron_index(neuron_index), .activation(activation),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exp(-t) in Q.30 from a truncated series of exp(-t/16), squared four times
  function automatic longint unsigned exp_q30(input longint unsigned t_in);
    longint unsigned term;
    longint sum;
    longint unsigned t;
    term = 64'd1 << 30;
    sum = longint'(64'd1 << 30);
    t = t_in >> 4;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * t) >> 30) / longint'(k);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    term = longint'(sum);
    for (int i = 0; i < 4; i++) term = (term * term) >> 30;
    return term;
  endfunction

  task automatic fill_sigmoid_lut();
    longint mid;
    longint unsigned mag, e, den, num;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      mid = -(longint'(8) << 24) + ((2 * longint'(i) + 1) * (longint'(16) << 24)) /
            (2 * longint'(SIG_ENTRIES));
      mag = (mid < 0) ? -mid : mid;
      e = exp_q30(mag << 6);
      den = (64'd1 << 30) + e;
      num = (mid >= 0) ? (64'd4096 << 30) : 64'd4096 * e;
      sig_lut[i] = 16'((num + den / 2) / den);
    end
  endtask

  // Update the layer model with one accepted item; queue the read result
  task automatic layer_apply(input logic [2:0] cmd, input logic [NEURON_W-1:0] n,
                             input logic [COL_W-1:0] c, input logic signed [VAL_W-1:0] v);
    int addr;
    longint prod, accs, sum, z;
    act_t r;
    addr = int'(n) * MAX_INPUTS + int'(c);
    case (cmd)
      CMD_WEIGHT: begin
        weight_mem[addr] = v;
        if (!weight_set[addr]) begin
          weight_set[addr] = 1'b1;
          col_fill[c]++;
        end
      end
      CMD_BIAS: bias_mem[n] = v;
      CMD_FEED: begin
        for (int k = 0; k < used_neurons; k++) begin
          prod = longint'(weight_mem[k * MAX_INPUTS + int'(c)]) * longint'(v);
          acc_mem[k] = acc_mem[k] + prod[ACC_W-1:0];
        end
      end
      CMD_READ: begin
        if (int'(n) < used_neurons) begin
          accs = longint'(signed'(acc_mem[n]));
          sum = accs + longint'(bias_mem[n]) * 4096;
          z = (sum + 2048) >>> 12;
          if (z > 32767) z = 32767;
          if (z < -32768) z = -32768;
          r.neuron_index = n;
          if (linear_mode) r.activation = 16'(z);
          else r.activation = sig_lut[(z + 32768) >> 6];
          if (typed_next) r.activation = typed_val;
          pending_acts.push_back(r);
        end
      end
      CMD_CLEAR: for (int k = 0; k < MAX_NEURONS; k++) acc_mem[k] = '0;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_acts.size() == 0) begin
        report_mismatch("result with nothing pending, neuron", int'(neuron_index), -1);
      end else begin
        act_t w;
        w = pending_acts.pop_front();
        reads_checked++;
        if (neuron_index !== w.neuron_index)
          report_mismatch("neuron_index", int'(neuron_index), int'(w.neuron_index));
        if (activation !== w.activation)
          report_mismatch("activation", int'(activation), int'(w.activation));
      end
    end
  end

  // Present one item and hold it until accepted
  task automatic send_item(input logic [2:0] cmd, input logic [NEURON_W-1:0] n,
                           input logic [COL_W-1:0] c, input logic signed [VAL_W-1:0] v);
    @(negedge clk);
    start = 1'b1;
    command = cmd;
    neuron = n;
    column = c;
    value = v;
    do @(posedge clk); while (busy);
    layer_apply(cmd, n, c, v);
    items_sent++;
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Drain the block, then write one register
  task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] data);
    idle_for(1);
    wait (pending_acts.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == 1'b0) used_neurons = (int'(data) < MAX_NEURONS) ? int'(data) : MAX_NEURONS;
    else linear_mode = data[0];
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random traffic under the current settings, sent in bursts
  task automatic random_phase(input int count);
    int burst;
    int pick;
    logic [NEURON_W-1:0] n;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
      end
      burst--;
      pick = $urandom_range(0, 99);
      if (used_neurons > 0 && $urandom_range(0, 4) != 0)
        n = NEURON_W'($urandom_range(0, used_neurons - 1));
      else
        n = NEURON_W'($urandom);
      if (pick < 32)
        send_item(CMD_FEED, NEURON_W'($urandom), COL_W'(ready_cols[$urandom_range(0, NUM_READY-1)]),
                  rand_value());
      else if (pick < 60)
        send_item(CMD_READ, n, COL_W'($urandom), 16'($urandom));
      else if (pick < 70)
        send_item(CMD_WEIGHT, NEURON_W'($urandom),
                  COL_W'(ready_cols[$urandom_range(0, NUM_READY-1)]), rand_value());
      else if (pick < 80)
        send_item(CMD_WEIGHT, NEURON_W'($urandom), COL_W'($urandom), rand_value());
      else if (pick < 89)
        send_item(CMD_BIAS, NEURON_W'($urandom), COL_W'($urandom), rand_value());
      else if (pick < 94)
        send_item(CMD_CLEAR, NEURON_W'($urandom), COL_W'($urandom), 16'($urandom));
      else
        send_item(3'($urandom_range(5, 7)), NEURON_W'($urandom), COL_W'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    row_t rows [$];
    int cfg_counts [7];
    bit cfg_linear [7];
    logic signed [VAL_W-1:0] b;

    cfg_counts = '{128, 1, 37, 0, 255, 128, 5};
    cfg_linear = '{0, 1, 0, 0, 1, 1, 0};
    used_neurons = MAX_NEURONS;
    linear_mode = 1'b0;
    for (int k = 0; k < MAX_NEURONS; k++) acc_mem[k] = '0;
    for (int k = 0; k < MAX_INPUTS; k++) col_fill[k] = 0;
    fill_sigmoid_lut();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Load biases with zero on neuron 0 and extremes on neurons 1 and 127, then
    // weights of the columns that feeds will use
    for (int k = 0; k < MAX_NEURONS; k++) begin
      b = rand_value();
      if (k == 0) b = 16'sd0;
      if (k == 1) b = 16'sh8000;
      if (k == 127) b = 16'sh7FFF;
      send_item(CMD_BIAS, NEURON_W'(k), COL_W'($urandom), b);
    end
    foreach (ready_cols[j])
      for (int k = 0; k < MAX_NEURONS; k++)
        send_item(CMD_WEIGHT, NEURON_W'(k), COL_W'(ready_cols[j]), rand_value());

    // Directed items in linear mode; typed results come from zero accumulators
    write_reg(1'b1, 8'd1);
    rows.push_back('{CMD_READ,   7'd0,   10'd0,    16'sd0,      1, 16'sd0});
    rows.push_back('{CMD_READ,   7'd127, 10'd0,    16'sd0,      1, 16'sh7FFF});
    rows.push_back('{CMD_READ,   7'd1,   10'd0,    16'sd0,      1, 16'sh8000});
    rows.push_back('{CMD_FEED,   7'd0,   10'd0,    16'sh7FFF,   0, 16'sd0});
    rows.push_back('{CMD_FEED,   7'd0,   10'd1023, 16'sh8000,   0, 16'sd0});
    rows.push_back('{CMD_READ,   7'd0,   10'd0,    16'sd0,      0, 16'sd0});
    rows.push_back('{CMD_READ,   7'd127, 10'd0,    16'sd0,      0, 16'sd0});
    rows.push_back('{CMD_WEIGHT, 7'd5,   10'd0,    16'sh8000,   0, 16'sd0});
    rows.push_back('{CMD_WEIGHT, 7'd6,   10'd1023, 16'sh7FFF,   0, 16'sd0});
    rows.push_back('{CMD_FEED,   7'd0,   10'd0,    16'sh8000,   0, 16'sd0});
    rows.push_back('{3'd5,       7'd3,   10'd0,    16'sd0,      0, 16'sd0});
    rows.push_back('{3'd6,       7'd3,   10'd1023, 16'sh7FFF,   0, 16'sd0});
    rows.push_back('{3'd7,       7'd127, 10'd1023, 16'sh8000,   0, 16'sd0});
    rows.push_back('{CMD_READ,   7'd5,   10'd0,    16'sd0,      0, 16'sd0});
    rows.push_back('{CMD_READ,   7'd6,   10'd0,    16'sd0,      0, 16'sd0});
    rows.push_back('{CMD_BIAS,   7'd2,   10'd0,    16'sh7FFF,   0, 16'sd0});
    rows.push_back('{CMD_READ,   7'd2,   10'd0,    16'sd0,      0, 16'sd0});
    rows.push_back('{CMD_CLEAR,  7'd0,   10'd0,    16'sd0,      0, 16'sd0});
    rows.push_back('{CMD_READ,   7'd2,   10'd0,    16'sd0,      1, 16'sh7FFF});
    rows.push_back('{CMD_READ,   7'd0,   10'd0,    16'sd0,      1, 16'sd0});
    foreach (rows[i]) begin
      typed_next = rows[i].typed;
      typed_val = rows[i].typed_act;
      send_item(rows[i].cmd, rows[i].neuron, rows[i].column, rows[i].value);
      typed_next = 1'b0;
    end

    // Random traffic over a series of register settings
    for (int s = 0; s < 7; s++) begin
      write_reg(1'b0, COUNT_W'(cfg_counts[s]));
      write_reg(1'b1, COUNT_W'(cfg_linear[s]));
      random_phase(s == 3 ? 20 : 30);
    end

    idle_for(1);
    wait (pending_acts.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d items and %0d checked reads over seven register settings",
             items_sent, reads_checked);
    if (mismatches == 0 && pending_acts.size() == 0)
      $display("** dense_layer_sigmoid_forward: PASSED **");
    else
      $display("** dense_layer_sigmoid_forward: FAILED **");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still pending", pending_acts.size());
    $display("** dense_layer_sigmoid_forward: FAILED **");
    $finish;
  end

endmodule
